// File: src/bounded_stack_with_successor_query_unit_defines.svh
// Assertion macros shared by the checker of the stack unit.
`ifndef BOUNDED_STACK_WITH_SUCCESSOR_QUERY_UNIT_DEFINES_SVH
`define BOUNDED_STACK_WITH_SUCCESSOR_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bsq_pkg.sv
// Shared types, codes and sizes of the bounded stack unit.
package bsq_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int WORD_W        = 32;
   localparam int CAP_W         = 9;
   localparam int CNT_W         = 9;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOLARGER = 2'd3;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [WORD_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      logic [1:0]               status;
      logic [CNT_W-1:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic       push;
      logic       pop;
      logic       take_pop;
      logic       scan_start;
      logic       scan_step;
      logic       scan_end;
      logic       set_res;
      logic [1:0] res_status;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       scan_last;
      logic       out_free;
   } sts_type;

endpackage

// File: src/bsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bsq_ctrl.sv
// Sequencer of the stack unit: walks each item through execute, the scan for a query, and output.
module bsq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsq_pkg::sts_type sts,
   output bsq_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EXEC      = 3'd1;
   localparam logic [2:0] S_POP_WAIT  = 3'd2;
   localparam logic [2:0] S_SCAN      = 3'd3;
   localparam logic [2:0] S_SCAN_TAIL = 3'd4;
   localparam logic [2:0] S_SCAN_END  = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               bsq_pkg::OP_PUSH: begin
                  cmd.set_res = 1'b1;
                  if (sts.full) begin
                     cmd.res_status = bsq_pkg::ST_OVERFLOW;
                  end else begin
                     cmd.push       = 1'b1;
                     cmd.res_status = bsq_pkg::ST_OK;
                  end
                  state_in = S_DONE;
               end
               bsq_pkg::OP_POP: begin
                  if (sts.empty) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = bsq_pkg::ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = S_POP_WAIT;
                  end
               end
               bsq_pkg::OP_QUERY: begin
                  if (sts.empty) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = bsq_pkg::ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = bsq_pkg::ST_OK;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.take_pop = 1'b1;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SCAN_TAIL;
            end
         end
         S_SCAN_TAIL: begin
            // The last word read comes out of the RAM and is compared here.
            state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            cmd.scan_end = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/bsq_datapath.sv
// Datapath of the stack unit: fill count, entry RAM, successor search and output register.
module bsq_datapath #(
   parameter int DEPTH = bsq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bsq_pkg::req_type              req_data,
   input  logic                          csr_valid,
   input  logic [bsq_pkg::CAP_W-1:0]     csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bsq_pkg::rsp_type              rsp_data,
   input  bsq_pkg::cmd_type              cmd,
   output bsq_pkg::sts_type              sts
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = ($clog2(DEPTH + 1) > bsq_pkg::CNT_W) ?
                           $clog2(DEPTH + 1) : bsq_pkg::CNT_W;
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);

   logic [1:0]                       op_ff;
   logic signed [bsq_pkg::WORD_W-1:0] operand_ff;
   logic [bsq_pkg::CAP_W-1:0]        capacity_ff;
   logic [FILL_W-1:0]                fill_ff;
   logic [FILL_W-1:0]                fill_in;
   logic [FILL_W-1:0]                fill_dec;
   logic [ADDR_W-1:0]                scan_idx_ff;
   logic                             cmp_valid_ff;
   logic                             found_ff;
   logic signed [bsq_pkg::WORD_W-1:0] best_ff;
   logic signed [bsq_pkg::WORD_W-1:0] res_value_ff;
   logic [1:0]                       res_status_ff;
   logic                             rsp_valid_ff;
   bsq_pkg::rsp_type                 rsp_data_ff;

   logic [ADDR_W-1:0]                rd_addr;
   logic [bsq_pkg::WORD_W-1:0]       rd_data;
   logic signed [bsq_pkg::WORD_W-1:0] rd_word;
   logic                             take_word;
   logic                             full;

   assign fill_dec = fill_ff - FILL_W'(1);
   assign rd_word  = $signed(rd_data);
   assign rd_addr  = cmd.pop ? fill_dec[ADDR_W-1:0] : scan_idx_ff;

   // The capacity saturates at the RAM depth.
   assign full = (fill_ff >= FILL_W'(capacity_ff)) || (fill_ff >= DEPTH_FILL);

   bsq_ram #(
      .WIDTH (bsq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (operand_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_dec;
      end
   end

   // A word qualifies when above the threshold and below the best so far.
   assign take_word = cmp_valid_ff && (rd_word > operand_ff) &&
                      (!found_ff || (rd_word < best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         capacity_ff  <= bsq_pkg::CAP_RESET;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmd.scan_step;
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
         end else if (take_word) begin
            found_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_data.opcode;
         operand_ff <= req_data.operand_value;
      end
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + ADDR_W'(1);
      end
      if (take_word) begin
         best_ff <= rd_word;
      end
      if (cmd.set_res) begin
         res_value_ff  <= '0;
         res_status_ff <= cmd.res_status;
      end else if (cmd.take_pop) begin
         res_value_ff  <= rd_word;
         res_status_ff <= bsq_pkg::ST_OK;
      end else if (cmd.scan_end) begin
         res_value_ff  <= found_ff ? best_ff : '0;
         res_status_ff <= found_ff ? bsq_pkg::ST_OK : bsq_pkg::ST_NOLARGER;
      end
      if (cmd.out_load) begin
         rsp_data_ff.result_value <= res_value_ff;
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.entry_count  <= fill_ff[bsq_pkg::CNT_W-1:0];
      end
   end

   assign sts.op        = op_ff;
   assign sts.full      = full;
   assign sts.empty     = (fill_ff == '0);
   assign sts.scan_last = (scan_idx_ff == fill_dec[ADDR_W-1:0]);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/bounded_stack_with_successor_query_unit.sv
// Bounded LIFO stack of signed words with a smallest-greater-entry search.
// One item is worked at a time and each item gives exactly one result. The result register
// is loaded in the done state, which a push, a failed pop or query, or an unused opcode
// reaches straight from the execute state, a pop by way of a pop-wait state, and a
// successor query over N stored entries by way of a scan that reads the entry RAM through
// its single read port one word per cycle, then the scan-tail and scan-end states; a result
// still held by a stalled receiver delays the load for as long as the stall lasts. The input
// accepts again in the cycle after the load. The entry RAM needs no clearing after reset.
// The capacity register may be written through the csr port only while the unit is idle.
module bounded_stack_with_successor_query_unit #(
   parameter int DEPTH = bsq_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bsq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bsq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bsq_pkg::CAP_W-1:0] csr_data
);

   bsq_pkg::cmd_type cmd;
   bsq_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   bsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: src/bsq_checker.sv
// Port-level checker of the stack unit and its bind to the top level.
`include "bounded_stack_with_successor_query_unit_defines.svh"

module bsq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bsq_pkg::rsp_type rsp_data
);

   // A held result must not change while the receiver stalls.
   `BSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // The unit works on one item at a time, so it stalls right after taking one.
   `BSQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second item taken while busy")

   // Every failing status carries a zero value.
   `BSQ_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_data.status != bsq_pkg::ST_OK), rsp_data.result_value == '0, "nonzero value with failing status")

   // An empty status can only be reported with no entries held.
   `BSQ_ASSERT_NOW(a_empty_count, rsp_valid && (rsp_data.status == bsq_pkg::ST_EMPTY), rsp_data.entry_count == '0, "empty status with entries held")

endmodule

bind bounded_stack_with_successor_query_unit bsq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/bounded_stack_with_successor_query_unit_tb.sv
// Self-checking testbench for the bounded stack unit with successor query.
module bounded_stack_with_successor_query_unit_tb;
   import bsq_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 300;
   localparam longint LIMIT_TIME = 64'd50_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   // Shadow of the stack contents and the capacity register.
   logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
   int                       shadow_fill = 0;
   logic [CAP_W-1:0]         shadow_capacity = CAP_RESET;

   rsp_type awaited_results [$];
   int      failures = 0;
   bit      idle_on = 1'b1;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   int n_push = 0, n_pop = 0, n_query = 0, n_unused = 0;
   int n_overflow = 0, n_empty = 0, n_nolarger = 0, n_cap_writes = 0, deepest_fill = 0;

   bounded_stack_with_successor_query_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one item to the shadow stack and returns the result it must produce.
   function automatic rsp_type apply_stack_item(req_type item);
      rsp_type                  res;
      int                       limit;
      logic                     found;
      logic signed [WORD_W-1:0] best;
      logic signed [WORD_W-1:0] threshold;
      res = '0;
      limit = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_capacity);
      found = 1'b0;
      best = '0;
      threshold = item.operand_value;
      case (item.opcode)
         OP_PUSH: begin
            if (shadow_fill >= limit) begin
               res.status = ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = threshold;
               shadow_fill++;
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_fill--;
               res.result_value = shadow_words[shadow_fill];
            end
         end
         OP_QUERY: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_fill; i++) begin
                  if (shadow_words[i] > threshold && (!found || shadow_words[i] < best)) begin
                     best = shadow_words[i];
                     found = 1'b1;
                  end
               end
               if (found) res.result_value = best;
               else res.status = ST_NOLARGER;
            end
         end
         default: ;
      endcase
      res.entry_count = shadow_fill[CNT_W-1:0];
      return res;
   endfunction

   // Offers one item, possibly after a random gap, and records its expected result.
   task automatic send_item(logic [1:0] op, logic signed [WORD_W-1:0] value);
      req_type item;
      rsp_type want;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      item.opcode = op;
      item.operand_value = value;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      want = apply_stack_item(item);
      awaited_results.push_back(want);
      case (op)
         OP_PUSH:  n_push++;
         OP_POP:   n_pop++;
         OP_QUERY: n_query++;
         default:  n_unused++;
      endcase
      if (want.status == ST_OVERFLOW) n_overflow++;
      if (want.status == ST_EMPTY) n_empty++;
      if (want.status == ST_NOLARGER) n_nolarger++;
      if (shadow_fill > deepest_fill) deepest_fill = shadow_fill;
   endtask

   // Drops the request and waits until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_capacity = cap;
      n_cap_writes++;
   endtask

   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) != 0) ? WORD_MIN : WORD_MAX;
         1: return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd0;
         2, 3, 4: return int'($urandom_range(0, 32)) - 16;
         default: return $urandom;
      endcase
   endfunction

   // Thresholds cluster around stored words so that equal and neighbor cases come up.
   function automatic logic signed [WORD_W-1:0] query_threshold();
      logic signed [WORD_W-1:0] w;
      if (shadow_fill > 0 && $urandom_range(0, 1) != 0) begin
         w = shadow_words[$urandom_range(0, shadow_fill - 1)];
         case ($urandom_range(0, 2))
            0: return w;
            1: return w - 1;
            default: return w + 1;
         endcase
      end
      return random_word();
   endfunction

   task automatic send_random(int push_weight, int pop_weight, int query_weight);
      int pick;
      pick = $urandom_range(0, push_weight + pop_weight + query_weight - 1);
      if ($urandom_range(0, 39) == 0) send_item(OP_UNUSED, $urandom);
      else if (pick < push_weight) send_item(OP_PUSH, random_word());
      else if (pick < push_weight + pop_weight) send_item(OP_POP, random_word());
      else send_item(OP_QUERY, query_threshold());
   endtask

   task automatic run_random(int count, int push_weight, int pop_weight, int query_weight);
      repeat (count) send_random(push_weight, pop_weight, query_weight);
   endtask

   task automatic test_directed_corners();
      send_item(OP_POP, 32'sd0);
      send_item(OP_QUERY, 32'sd0);
      send_item(OP_UNUSED, WORD_MAX);
      send_item(OP_PUSH, WORD_MIN);
      send_item(OP_PUSH, WORD_MAX);
      send_item(OP_PUSH, -32'sd1);
      send_item(OP_PUSH, 32'sd0);
      send_item(OP_PUSH, 32'sd5);
      send_item(OP_PUSH, 32'sd5);
      send_item(OP_QUERY, WORD_MIN);
      send_item(OP_QUERY, -32'sd2);
      send_item(OP_QUERY, -32'sd1);
      send_item(OP_QUERY, 32'sd4);
      send_item(OP_QUERY, 32'sd5);
      send_item(OP_QUERY, WORD_MAX - 1);
      send_item(OP_QUERY, WORD_MAX);
      send_item(OP_UNUSED, -32'sd1);
      repeat (7) send_item(OP_POP, 32'sd0);
      send_item(OP_QUERY, WORD_MIN);
   endtask

   task automatic test_capacity_extremes();
      write_capacity(9'd1);
      send_item(OP_PUSH, 32'sd7);
      send_item(OP_PUSH, 32'sd8);
      send_item(OP_QUERY, 32'sd0);
      send_item(OP_POP, 32'sd0);
      write_capacity(9'd0);
      send_item(OP_PUSH, -32'sd1);
      send_item(OP_POP, 32'sd0);
      // A capacity above the store depth still stops at the store depth.
      write_capacity(9'd511);
      while (shadow_fill < STACK_DEPTH) send_item(OP_PUSH, random_word());
      send_item(OP_PUSH, random_word());
      send_item(OP_QUERY, query_threshold());
      send_item(OP_QUERY, WORD_MIN);
      write_capacity(CAP_RESET);
      send_item(OP_PUSH, random_word());
      while (shadow_fill > 0) begin
         if ($urandom_range(0, 9) == 0) send_item(OP_QUERY, query_threshold());
         else send_item(OP_POP, 32'sd0);
      end
   endtask

   task automatic test_capacity_below_fill();
      write_capacity(CAP_RESET);
      repeat (12) send_item(OP_PUSH, random_word());
      write_capacity(9'd4);
      repeat (3) send_item(OP_PUSH, random_word());
      repeat (2) send_item(OP_QUERY, query_threshold());
      repeat (9) send_item(OP_POP, 32'sd0);
      send_item(OP_PUSH, random_word());
      send_item(OP_PUSH, random_word());
      write_capacity(9'($urandom_range(1, 256)));
      run_random(20, 2, 3, 2);
   endtask

   task automatic test_receiver_hold();
      bit saved_idle;
      saved_idle = idle_on;
      idle_on = 1'b0;
      // The receiver process picks this up and holds off while items keep coming.
      hold_requests++;
      run_random(16, 2, 1, 1);
      idle_on = saved_idle;
   endtask

   task automatic test_sender_pause();
      run_random(10, 2, 1, 1);
      drain_results();
      run_random(10, 1, 1, 2);
   endtask

   task automatic test_random_mix();
      logic [CAP_W-1:0] caps [6];
      caps[0] = CAP_RESET;
      caps[1] = 9'($urandom_range(1, 16));
      caps[2] = 9'd2;
      caps[3] = 9'd255;
      caps[4] = 9'($urandom_range(0, 511));
      caps[5] = 9'd64;
      for (int phase = 0; phase < 6; phase++) begin
         write_capacity(caps[phase]);
         case (phase % 3)
            0: run_random(150, 5, 2, 3);
            1: run_random(150, 2, 5, 3);
            default: run_random(150, 3, 3, 4);
         endcase
      end
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      write_capacity(9'($urandom_range(1, 256)));
      run_random(150, 3, 2, 3);
   endtask

   // Receiver side: random stall bursts plus the long hold-off requested by a test.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (holds_served < hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result with none awaited: value %0d status %0d count %0d",
                   rsp_data.result_value, rsp_data.status, rsp_data.entry_count);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               $error("result_value: expected %0d, actual %0d",
                      want.result_value, rsp_data.result_value);
               failures++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_data.entry_count);
               failures++;
            end
         end
      end
   end

   initial begin
      #(LIMIT_TIME);
      $display("bounded_stack_with_successor_query_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_capacity_extremes();
      test_capacity_below_fill();
      test_receiver_hold();
      test_sender_pause();
      test_random_mix();
      test_quiet_tail();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d pushes (%0d overflowed), %0d pops, %0d queries, %0d unused opcodes.",
               n_push, n_overflow, n_pop, n_query, n_unused);
      $display("Saw %0d empty and %0d no-larger results, %0d capacity writes, fill up to %0d.",
               n_empty, n_nolarger, n_cap_writes, deepest_fill);
      if (failures == 0) begin
         $display("bounded_stack_with_successor_query_unit regression: pass");
      end else begin
         $display("bounded_stack_with_successor_query_unit regression: fail");
      end
      $finish;
   end

endmodule
